/* rtl/xfr_pkg.sv */
package xfr_pkg;

    localparam int STORE_DEPTH_DEF = 64;

    localparam int BYTE_W = 8;
    localparam int RIDX_W = 6;
    localparam int FLEN_W = 7;
    localparam int STAT_W = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd177;
    localparam logic [BYTE_W-1:0] CHECKSUM_SEED_RST = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_SEED = 1'b1;

    localparam logic OP_RX = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_IDLE     = 3'd0,
        ST_DISCARD  = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_GOOD     = 3'd3,
        ST_BAD      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'b001,
        PH_BODY  = 3'b010,
        PH_CHECK = 3'b100
    } t_phase;

    typedef struct packed {
        t_status            status;
        logic [FLEN_W-1:0]  frame_length;
        logic               rd_valid;
    } t_ctrl_res;

endpackage

/* rtl/xfr_in_if.sv */
interface xfr_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;
    logic [5:0] read_index;

    modport source (output valid, output op, output rx_byte, output read_index, input ready);
    modport sink (input valid, input op, input rx_byte, input read_index, output ready);
endinterface

/* rtl/xfr_out_if.sv */
interface xfr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [6:0] frame_length;
    logic [7:0] read_data;

    modport source (output valid, output status, output frame_length, output read_data,
                    input ready);
    modport sink (input valid, input status, input frame_length, input read_data,
                  output ready);
endinterface

/* rtl/xfr_ram.sv */
module xfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/xfr_ctrl.sv */
module xfr_ctrl import xfr_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [BYTE_W-1:0]              i_cfg_data,
    input  logic                           i_accept,
    input  logic                           i_op,
    input  logic [BYTE_W-1:0]              i_rx_byte,
    input  logic [RIDX_W-1:0]              i_read_index,
    output t_ctrl_res                      o_res,
    output logic                           o_ram_we,
    output logic [$clog2(STORE_DEPTH)-1:0] o_ram_waddr,
    output logic [BYTE_W-1:0]              o_ram_wdata,
    output logic [$clog2(STORE_DEPTH)-1:0] o_ram_raddr
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    logic [BYTE_W-1:0] r_start_marker;
    logic [BYTE_W-1:0] r_seed;
    t_phase            r_phase;
    t_phase            n_phase;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [BYTE_W-1:0] r_xor;
    logic [BYTE_W-1:0] n_xor;
    logic [BYTE_W-1:0] r_len;
    logic [BYTE_W-1:0] n_len;
    logic [7:0]        w_ridx8;
    logic [7:0]        w_cnt8;
    logic [7:0]        w_len_cmp;

    assign w_ridx8 = 8'(i_read_index);
    assign w_cnt8 = 8'(r_count);
    assign w_len_cmp = (r_count == '0) ? i_rx_byte : r_len;

    assign o_ram_raddr = w_ridx8[AW-1:0];
    assign o_ram_waddr = r_count[AW-1:0];
    assign o_ram_wdata = i_rx_byte;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_xor = r_xor;
        n_len = r_len;
        o_ram_we = 1'b0;
        o_res.status = ST_IDLE;
        o_res.frame_length = '0;
        o_res.rd_valid = (i_op == OP_READ) && (w_ridx8 < 8'(STORE_DEPTH));
        if (i_accept && (i_op == OP_RX)) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == r_start_marker) begin
                        n_count = '0;
                        n_xor = r_seed;
                        n_phase = PH_BODY;
                    end else begin
                        o_res.status = ST_DISCARD;
                    end
                end
                PH_BODY: begin
                    if (r_count < CW'(STORE_DEPTH)) begin
                        o_ram_we = 1'b1;
                        if (r_count == '0) begin
                            n_len = i_rx_byte;
                        end else begin
                            n_xor = r_xor ^ i_rx_byte;
                        end
                        n_count = r_count + CW'(1);
                        if (8'(n_count) == w_len_cmp) begin
                            n_phase = PH_CHECK;
                        end
                    end else begin
                        o_res.status = ST_OVERFLOW;
                        n_phase = PH_HUNT;
                    end
                end
                PH_CHECK: begin
                    o_res.status = (i_rx_byte == r_xor) ? ST_GOOD : ST_BAD;
                    o_res.frame_length = w_cnt8[FLEN_W-1:0];
                    n_xor = '0;
                    n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_seed <= CHECKSUM_SEED_RST;
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_xor <= '0;
            r_len <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_START_MARKER: r_start_marker <= i_cfg_data;
                    CFG_CHECKSUM_SEED: r_seed <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_phase <= n_phase;
            r_count <= n_count;
            r_xor <= n_xor;
            r_len <= n_len;
        end
    end

endmodule

/* rtl/xor_frame_receiver_unit.sv */
// Pipeline: an accepted transaction passes through two register stages, s1 and s2,
// and its result is held in s2 until the output is ready.
// Throughput: one transaction per cycle unless the output stalls; the frame store RAM
// takes one write and one read each cycle; control registers update at the accept edge.
// Reset: synchronous, active low; clears phase, count, XOR, length and the pipeline
// valid flags, and loads start_marker 177 and checksum_seed 255. The store is not cleared.
module xor_frame_receiver_unit import xfr_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    xfr_in_if.sink               i_in,
    xfr_out_if.source            o_out
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic              w_accept;
    logic              w_s1_adv;
    logic              w_s2_load;
    t_ctrl_res         w_res;
    logic              w_ram_we;
    logic [AW-1:0]     w_ram_waddr;
    logic [BYTE_W-1:0] w_ram_wdata;
    logic [AW-1:0]     w_ram_raddr;
    logic [BYTE_W-1:0] w_ram_rdata;

    logic              r_s1_valid;
    t_ctrl_res         r_s1_res;
    logic              r_s2_valid;
    t_status           r_s2_status;
    logic [FLEN_W-1:0] r_s2_flen;
    logic [BYTE_W-1:0] r_s2_rdata;

    assign w_s2_load = r_s1_valid && (!r_s2_valid || o_out.ready);
    assign w_s1_adv = !r_s1_valid || w_s2_load;
    assign i_in.ready = w_s1_adv;
    assign w_accept = i_in.valid && w_s1_adv;

    xfr_ctrl #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (w_accept),
        .i_op         (i_in.op),
        .i_rx_byte    (i_in.rx_byte),
        .i_read_index (i_in.read_index),
        .o_res        (w_res),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_raddr  (w_ram_raddr)
    );

    xfr_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_accept),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_s2_load) begin
                r_s2_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_res <= w_res;
        end
        if (w_s2_load) begin
            r_s2_status <= r_s1_res.status;
            r_s2_flen <= r_s1_res.frame_length;
            r_s2_rdata <= r_s1_res.rd_valid ? w_ram_rdata : '0;
        end
    end

    assign o_out.valid = r_s2_valid;
    assign o_out.status = r_s2_status;
    assign o_out.frame_length = r_s2_flen;
    assign o_out.read_data = r_s2_rdata;

endmodule
